>>> sv/box_sub_pkg.sv
// Shared types and constants for the box difference block.
// Used by box_subtract, box_sub_front and box_sub_back; depends on nothing else.
package box_sub_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_DIMS_DEF    = 3;

    // The stream words always carry fields for three dimensions.
    localparam int FIELD_DIMS      = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam int         CFG_W       = 2;
    localparam logic [1:0] DIMS_RESET  = 2'd3;

    // tuser bit positions on the result stream.
    localparam int USER_W     = 3;
    localparam int USER_EMPTY = 0;
    localparam int USER_DISJ  = 1;
    localparam int USER_MALF  = 2;

    // Coordinate slots kept per dimension in a queued job.
    localparam int COORDS_PER_DIM = 6;
    localparam int SLOT_AB = 0;
    localparam int SLOT_AE = 1;
    localparam int SLOT_BB = 2;
    localparam int SLOT_BE = 3;
    localparam int SLOT_IB = 4;
    localparam int SLOT_IE = 5;

    // Two possible pieces per dimension: lower part, then upper part.
    localparam int MASK_W = 2 * FIELD_DIMS;
    localparam int SEL_W  = $clog2(MASK_W);

    typedef enum logic [1:0] {
        KIND_PIECES,
        KIND_MALFORMED,
        KIND_DISJOINT,
        KIND_EMPTY
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [MASK_W-1:0] mask;
    } t_job_ctrl;

    localparam int CTRL_W = $bits(t_job_ctrl);

    function automatic int job_width(input int cw, input int md);
        return CTRL_W + COORDS_PER_DIM * cw * md;
    endfunction

    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

>>> sv/box_subtract.sv
// Top level of the box difference block: configuration register, front end,
// job queue and back end. Depends on box_sub_pkg and the box_sub_* modules.
//
// For every pair of boxes A and B accepted on the input stream, the block
// sends the disjoint boxes whose union is A minus B, one word per cycle while
// m_axis_tready is high, with tlast on the final word of the pair. Each used
// dimension gives at most a lower and an upper piece, so one pair yields 1 to
// 2*dims_in_use words; disjoint, covered and malformed pairs yield exactly one
// word with the matching tuser flag. A pair is accepted every cycle while the
// two-entry job queue has room, so new pairs can be taken while the words of
// an earlier pair are still being sent; a pair leaves the queue when its last
// word is loaded into the output register. A word passes through the job
// queue and then the output register. The user must see that dims_in_use is
// written only while the block is idle; the block itself does not enforce this.
module box_subtract #(
    parameter int COORD_WIDTH = box_sub_pkg::COORD_WIDTH_DEF,
    parameter int MAX_DIMS    = box_sub_pkg::MAX_DIMS_DEF,
    localparam int IN_W  = box_sub_pkg::byte_round(4 * box_sub_pkg::FIELD_DIMS * COORD_WIDTH),
    localparam int OUT_W = box_sub_pkg::byte_round(2 * box_sub_pkg::FIELD_DIMS * COORD_WIDTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [box_sub_pkg::CFG_W-1:0]  i_cfg_wr_data,  // dims_in_use
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // a_begin_0, a_end_0, a_begin_1, a_end_1, a_begin_2, a_end_2,
    // b_begin_0, b_end_0, b_begin_1, b_end_1, b_begin_2, b_end_2
    input  logic [IN_W-1:0]                s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // piece_begin_0, piece_end_0, piece_begin_1, piece_end_1,
    // piece_begin_2, piece_end_2
    output logic [OUT_W-1:0]               m_axis_tdata,
    // empty_result, disjoint, malformed
    output logic [box_sub_pkg::USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast  // last_piece
);
    localparam int JOB_W = box_sub_pkg::job_width(COORD_WIDTH, MAX_DIMS);

    logic [box_sub_pkg::CFG_W-1:0] r_dims;
    logic                          push, full, pop, job_valid;
    logic [JOB_W-1:0]              job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= box_sub_pkg::DIMS_RESET;
        end else if (i_cfg_wr_en) begin
            r_dims <= i_cfg_wr_data;
        end
    end

    box_sub_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_DIMS    (MAX_DIMS)
    ) u_front (
        .i_dims  (r_dims),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    box_sub_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (box_sub_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job_out)
    );

    box_sub_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_DIMS    (MAX_DIMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_user      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

>>> sv/box_sub_fifo.sv
// Small register queue between the classifier and the piece generator.
// Generic in width and depth; uses no package items.
module box_sub_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> sv/box_sub_front.sv
// Front end: accepts box pairs, checks them and works out which pieces exist.
// Depends on box_sub_pkg; feeds box_sub_fifo.
module box_sub_front #(
    parameter int COORD_WIDTH = box_sub_pkg::COORD_WIDTH_DEF,
    parameter int MAX_DIMS    = box_sub_pkg::MAX_DIMS_DEF,
    localparam int IN_W  = box_sub_pkg::byte_round(4 * box_sub_pkg::FIELD_DIMS * COORD_WIDTH),
    localparam int JOB_W = box_sub_pkg::job_width(COORD_WIDTH, MAX_DIMS)
) (
    input  logic [box_sub_pkg::CFG_W-1:0] i_dims,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [IN_W-1:0]               i_data,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [JOB_W-1:0]              o_job
);
    localparam int CW = COORD_WIDTH;
    localparam int B_OFS = 2 * box_sub_pkg::FIELD_DIMS;

    logic [box_sub_pkg::CFG_W-1:0]         nd;
    logic [COORD_WIDTH*MAX_DIMS*box_sub_pkg::COORDS_PER_DIM-1:0] coords;
    box_sub_pkg::t_job_ctrl                ctrl;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_job   = {coords, ctrl};

    always_comb begin
        logic signed [CW-1:0] ab, ae, bb, be;
        logic                 used, malf, overlap;
        logic [box_sub_pkg::MASK_W-1:0] mask;
        int                   base;

        nd = (i_dims == '0) ? box_sub_pkg::CFG_W'(1) : i_dims;
        if (int'(nd) > MAX_DIMS) begin
            nd = box_sub_pkg::CFG_W'(MAX_DIMS);
        end

        malf    = 1'b0;
        overlap = 1'b1;
        mask    = '0;
        coords  = '0;
        ab = '0; ae = '0; bb = '0; be = '0;
        used = 1'b0;
        base = 0;

        for (int d = 0; d < MAX_DIMS; d++) begin
            used = (d < int'(nd));
            ab = $signed(i_data[(2*d)*CW +: CW]);
            ae = $signed(i_data[(2*d+1)*CW +: CW]);
            bb = $signed(i_data[(B_OFS+2*d)*CW +: CW]);
            be = $signed(i_data[(B_OFS+2*d+1)*CW +: CW]);
            base = d * box_sub_pkg::COORDS_PER_DIM;
            if (used) begin
                if (ab >= ae || bb >= be) begin
                    malf = 1'b1;
                end
                if (!(ab < be && bb < ae)) begin
                    overlap = 1'b0;
                end
                // With the boxes overlapping, a lower part of A exists when A
                // starts before B, and an upper part when A ends after B.
                mask[2*d]   = (ab < bb);
                mask[2*d+1] = (ae > be);
                coords[(base+box_sub_pkg::SLOT_AB)*CW +: CW] = ab;
                coords[(base+box_sub_pkg::SLOT_AE)*CW +: CW] = ae;
                coords[(base+box_sub_pkg::SLOT_BB)*CW +: CW] = bb;
                coords[(base+box_sub_pkg::SLOT_BE)*CW +: CW] = be;
                coords[(base+box_sub_pkg::SLOT_IB)*CW +: CW] = (ab >= bb) ? ab : bb;
                coords[(base+box_sub_pkg::SLOT_IE)*CW +: CW] = (ae <= be) ? ae : be;
            end
        end

        ctrl.mask = mask;
        if (malf) begin
            ctrl.kind = box_sub_pkg::KIND_MALFORMED;
        end else if (!overlap) begin
            ctrl.kind = box_sub_pkg::KIND_DISJOINT;
        end else if (mask == '0) begin
            ctrl.kind = box_sub_pkg::KIND_EMPTY;
        end else begin
            ctrl.kind = box_sub_pkg::KIND_PIECES;
        end
    end

endmodule

>>> sv/box_sub_back.sv
// Back end: takes queued jobs and sends one result word per cycle unless the output stalls.
// Depends on box_sub_pkg; reads the head of box_sub_fifo.
module box_sub_back #(
    parameter int COORD_WIDTH = box_sub_pkg::COORD_WIDTH_DEF,
    parameter int MAX_DIMS    = box_sub_pkg::MAX_DIMS_DEF,
    localparam int OUT_W = box_sub_pkg::byte_round(2 * box_sub_pkg::FIELD_DIMS * COORD_WIDTH),
    localparam int JOB_W = box_sub_pkg::job_width(COORD_WIDTH, MAX_DIMS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  logic [JOB_W-1:0]               i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [OUT_W-1:0]               o_data,
    output logic [box_sub_pkg::USER_W-1:0] o_user,
    output logic                           o_last
);
    localparam int CW = COORD_WIDTH;
    localparam int MW = box_sub_pkg::MASK_W;
    localparam int SW = box_sub_pkg::SEL_W;

    box_sub_pkg::t_job_ctrl ctrl;
    logic [MW-1:0]          r_done, n_done;
    logic                   r_valid, n_valid;
    logic [OUT_W-1:0]       r_data, n_data;
    logic [box_sub_pkg::USER_W-1:0] r_user, n_user;
    logic                   r_last, n_last;
    logic [MW-1:0]          rem, pick;
    logic [SW-1:0]          sel;
    logic                   emit;

    assign ctrl    = box_sub_pkg::t_job_ctrl'(i_job[box_sub_pkg::CTRL_W-1:0]);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

    function automatic logic [CW-1:0] coord(input logic [JOB_W-1:0] job,
                                            input int d, input int slot);
        return job[box_sub_pkg::CTRL_W + (d*box_sub_pkg::COORDS_PER_DIM + slot)*CW +: CW];
    endfunction

    always_comb begin
        logic [SW-1:0] jd;

        rem = ctrl.mask & ~r_done;
        sel = '0;
        for (int j = MW - 1; j >= 0; j--) begin
            if (rem[j]) begin
                sel = SW'(j);
            end
        end
        pick = MW'(1) << sel;
        jd   = sel >> 1;

        emit    = i_job_valid && (!r_valid || i_ready);
        n_valid = r_valid && !i_ready;
        n_data  = r_data;
        n_user  = r_user;
        n_last  = r_last;
        n_done  = r_done;
        o_pop   = 1'b0;

        if (emit) begin
            n_valid = 1'b1;
            n_data  = '0;
            n_user  = '0;
            n_last  = 1'b1;
            case (ctrl.kind)
                box_sub_pkg::KIND_PIECES: begin
                    n_last = ((rem & ~pick) == '0);
                    // Earlier dimensions hold the intersection, later ones keep A.
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        if (d < int'(jd)) begin
                            n_data[(2*d)*CW +: CW]   = coord(i_job, d, box_sub_pkg::SLOT_IB);
                            n_data[(2*d+1)*CW +: CW] = coord(i_job, d, box_sub_pkg::SLOT_IE);
                        end else if (d == int'(jd)) begin
                            if (sel[0]) begin
                                n_data[(2*d)*CW +: CW]   = coord(i_job, d, box_sub_pkg::SLOT_BE);
                                n_data[(2*d+1)*CW +: CW] = coord(i_job, d, box_sub_pkg::SLOT_AE);
                            end else begin
                                n_data[(2*d)*CW +: CW]   = coord(i_job, d, box_sub_pkg::SLOT_AB);
                                n_data[(2*d+1)*CW +: CW] = coord(i_job, d, box_sub_pkg::SLOT_BB);
                            end
                        end else begin
                            n_data[(2*d)*CW +: CW]   = coord(i_job, d, box_sub_pkg::SLOT_AB);
                            n_data[(2*d+1)*CW +: CW] = coord(i_job, d, box_sub_pkg::SLOT_AE);
                        end
                    end
                end
                box_sub_pkg::KIND_DISJOINT: begin
                    n_user[box_sub_pkg::USER_DISJ] = 1'b1;
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        n_data[(2*d)*CW +: CW]   = coord(i_job, d, box_sub_pkg::SLOT_AB);
                        n_data[(2*d+1)*CW +: CW] = coord(i_job, d, box_sub_pkg::SLOT_AE);
                    end
                end
                box_sub_pkg::KIND_EMPTY: begin
                    n_user[box_sub_pkg::USER_EMPTY] = 1'b1;
                end
                box_sub_pkg::KIND_MALFORMED: begin
                    n_user[box_sub_pkg::USER_MALF] = 1'b1;
                end
                default: begin
                    n_user = '0;
                end
            endcase
            if (n_last) begin
                o_pop  = 1'b1;
                n_done = '0;
            end else begin
                n_done = r_done | pick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

endmodule
